FILE: rtl/core/kbsh_pkg.sv
`default_nettype none

package kbsh_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CNT_W         = $clog2(BITS_PER_BYTE + 1);

    localparam int TIMEOUT_W = 16;
    localparam int HOLD_W    = 8;
    localparam int BYTE_W    = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd50;
    localparam logic [HOLD_W-1:0]    HOLD_RESET    = 8'd1;

    // register byte addresses
    localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
    localparam logic [2:0] ADDR_HOLD    = 3'd4;

    typedef enum logic [1:0] {
        MODE_START_READ  = 2'd0,
        MODE_START_WRITE = 2'd1,
        MODE_CLK_EDGE    = 2'd2,
        MODE_TICK        = 2'd3
    } t_mode;

    // result item bit positions in m_tdata
    localparam int RES_DONE  = 0;
    localparam int RES_STAT  = 1;
    localparam int RES_READ  = 2;
    localparam int RES_BYTE  = 3;
    localparam int RES_DEN   = 11;
    localparam int RES_DLVL  = 12;
    localparam int RES_ARMED = 13;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef struct packed {
        logic              done_res;
        logic              status;
        logic              was_read;
        logic [BYTE_W-1:0] read_byte;
        logic              data_drive_enable;
        logic              data_drive_level;
        logic              edges_armed;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/keyboard_serial_byte_host.sv
// Channel   | Dir | Signals                          | Contents (low bit first)
// ----------+-----+----------------------------------+-------------------------------------
// s (cmd)   | in  | s_tvalid s_tready s_tuser s_tdata| tuser: mode[1:0];
//           |     |                                  | tdata: write_data[7:0], clock_level,
//           |     |                                  |        data_line, 6 zero bits
// m (res)   | out | m_tvalid m_tready m_tdata        | done_res, status, was_read,
//           |     |                                  | read_byte[7:0], data_drive_enable,
//           |     |                                  | data_drive_level, edges_armed, 2 zero
// cfg       | in  | APB psel penable pwrite paddr... | 0x0 timeout_ticks, 0x4 hold_ticks
//
// One item per cycle while no result stalls on m. Each accepted item updates the link
// state and loads the result register in the same edge; m shows its result next cycle.
// s_tready is low only while a result sits unread in the output register.
// Reset (synchronous, active low) leaves the link idle, data line released and
// high, capture disarmed, registers at timeout 50 / hold 1.
`default_nettype none

module keyboard_serial_byte_host (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [1:0]            s_tuser,   // mode
    input  wire logic [15:0]           s_tdata,   // write_data[7:0], clock_level, data_line

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,   // done_res, status, was_read,
                                                  // read_byte[7:0], data_drive_enable,
                                                  // data_drive_level, edges_armed

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import kbsh_pkg::*;

    // configuration
    logic [TIMEOUT_W-1:0] r_timeout_ticks;
    logic [HOLD_W-1:0]    r_hold_ticks;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
            r_hold_ticks    <= HOLD_RESET;
        end else if (cfg_wr) begin
            if (paddr == ADDR_TIMEOUT) r_timeout_ticks <= pwdata[TIMEOUT_W-1:0];
            if (paddr == ADDR_HOLD)    r_hold_ticks    <= pwdata[HOLD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_TIMEOUT) prdata = {{(32-TIMEOUT_W){1'b0}}, r_timeout_ticks};
        else if (paddr == ADDR_HOLD) prdata = {{(32-HOLD_W){1'b0}}, r_hold_ticks};
    end

    // link state; "transfer done" is always the inverse of r_active
    logic [BYTE_W-1:0]    r_shift,  n_shift;
    logic [CNT_W-1:0]     r_bits,   n_bits;
    logic                 r_rd,     n_rd;
    logic                 r_active, n_active;
    logic                 r_armed,  n_armed;
    logic [HOLD_W-1:0]    r_hold,   n_hold;
    logic [TIMEOUT_W-1:0] r_idle,   n_idle;
    logic                 r_den,    n_den;
    logic                 r_dlvl,   n_dlvl;

    // output register
    logic                 r_out_valid;
    t_result              r_res, n_res;

    t_mode                in_mode;
    logic [BYTE_W-1:0]    in_wdata;
    logic                 in_clk_lvl;
    logic                 in_din;
    logic                 s_acc;
    logic [TIMEOUT_W-1:0] idle_inc;

    assign in_mode    = t_mode'(s_tuser);
    assign in_wdata   = s_tdata[BYTE_W-1:0];
    assign in_clk_lvl = s_tdata[BYTE_W];
    assign in_din     = s_tdata[BYTE_W+1];

    assign s_tready = !r_out_valid || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // saturating idle counter
    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + 1'b1;

    always_comb begin
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_rd     = r_rd;
        n_active = r_active;
        n_armed  = r_armed;
        n_hold   = r_hold;
        n_idle   = r_idle;
        n_den    = r_den;
        n_dlvl   = r_dlvl;

        n_res           = '0;

        unique case (in_mode)
            MODE_START_READ: begin
                n_armed  = 1'b0;
                n_idle   = '0;
                n_shift  = '0;
                n_bits   = '0;
                n_rd     = 1'b1;
                n_active = 1'b1;
                n_hold   = r_hold_ticks;
            end
            MODE_START_WRITE: begin
                // pull data low as the request-to-send, capture armed at once
                n_idle   = '0;
                n_shift  = in_wdata;
                n_bits   = '0;
                n_rd     = 1'b0;
                n_active = 1'b1;
                n_hold   = '0;
                n_den    = 1'b1;
                n_dlvl   = 1'b0;
                n_armed  = 1'b1;
            end
            MODE_CLK_EDGE: begin
                if (r_armed) begin
                    if (r_bits < CNT_W'(BITS_PER_BYTE)) begin
                        // bit phase: falling edges only
                        if (!in_clk_lvl) begin
                            if (r_rd) begin
                                n_shift = {r_shift[BYTE_W-2:0], in_din};
                            end else begin
                                n_dlvl  = r_shift[BYTE_W-1];
                                n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                            end
                            n_bits = r_bits + 1'b1;
                        end
                    end else if (in_clk_lvl) begin
                        // closing rising edge
                        n_armed = 1'b0;
                        if (r_active) begin
                            n_active          = 1'b0;
                            n_idle            = '0;
                            n_res.done_res    = 1'b1;
                            n_res.status      = STATUS_OK;
                            n_res.was_read    = r_rd;
                            n_res.read_byte   = r_rd ? r_shift : '0;
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                    if (r_hold == HOLD_W'(1)) begin
                        // hold over: release data and listen
                        n_den   = 1'b0;
                        n_dlvl  = 1'b1;
                        n_armed = 1'b1;
                    end
                end
                if (r_active) begin
                    n_idle = idle_inc;
                    if (idle_inc > r_timeout_ticks) begin
                        n_active       = 1'b0;
                        n_res.done_res = 1'b1;
                        n_res.status   = STATUS_TIMEOUT;
                        n_res.was_read = r_rd;
                    end
                end
            end
            default: ;
        endcase

        n_res.data_drive_enable = n_den;
        n_res.data_drive_level  = n_dlvl;
        n_res.edges_armed       = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_bits      <= '0;
            r_rd        <= 1'b0;
            r_active    <= 1'b0;
            r_armed     <= 1'b0;
            r_hold      <= '0;
            r_idle      <= '0;
            r_den       <= 1'b0;
            r_dlvl      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_shift  <= n_shift;
                r_bits   <= n_bits;
                r_rd     <= n_rd;
                r_active <= n_active;
                r_armed  <= n_armed;
                r_hold   <= n_hold;
                r_idle   <= n_idle;
                r_den    <= n_den;
                r_dlvl   <= n_dlvl;
            end
            if (s_acc)         r_out_valid <= 1'b1;
            else if (m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) r_res <= n_res;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00,
                       r_res.edges_armed,
                       r_res.data_drive_level,
                       r_res.data_drive_enable,
                       r_res.read_byte,
                       r_res.was_read,
                       r_res.status,
                       r_res.done_res};

endmodule

`default_nettype wire

FILE: rtl/core/kbsh_checker.sv
`default_nettype none

module kbsh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    import kbsh_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an accepted item always yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    // no status, read flag or byte without completion; no byte on a write or a timeout
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (!m_tdata[RES_DONE] || !m_tdata[RES_READ] || m_tdata[RES_STAT])
        |-> m_tdata[RES_BYTE+7:RES_BYTE] == 8'h00
            && (m_tdata[RES_DONE] || (!m_tdata[RES_STAT] && !m_tdata[RES_READ])))
        else $error("result fields set without an ok read");

    // start write pulls data low and arms immediately
    a_wr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser == MODE_START_WRITE
        |=> m_tdata[RES_DEN] && !m_tdata[RES_DLVL] && m_tdata[RES_ARMED]
            && !m_tdata[RES_DONE])
        else $error("start write did not drive request");

    // start read disarms and reports nothing
    a_rd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser == MODE_START_READ
        |=> !m_tdata[RES_ARMED] && !m_tdata[RES_DONE])
        else $error("start read left capture armed");

endmodule

bind keyboard_serial_byte_host kbsh_checker u_kbsh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
